// ===== rtl/core/bpsm_pkg.sv =====
// Package for the battery power state monitor: request and state codes, charge table.
`default_nettype none
package bpsm_pkg;

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_LANDING = 2'd1,
    REQ_FORCE   = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  // Reported power states
  typedef enum logic [1:0] {
    PS_CHARGED  = 2'd0,
    PS_CHARGING = 2'd1,
    PS_LOWPOWER = 2'd2,
    PS_BATTERY  = 2'd3
  } power_state_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LOW_MV      = 3'd0,
    CFG_CRIT_MV     = 3'd1,
    CFG_LOW_TMO     = 3'd2,
    CFG_CRIT_TMO    = 3'd3,
    CFG_INACT_TMO   = 3'd4,
    CFG_LAND_CUTOFF = 3'd5,
    CFG_RSVD6       = 3'd6,
    CFG_RSVD7       = 3'd7
  } cfg_idx_e;

  localparam int unsigned MvW   = 14;
  localparam int unsigned TickW = 32;
  localparam int unsigned CutW  = 15;
  localparam int unsigned HgtW  = 16;
  localparam int unsigned PctW  = 7;
  localparam int unsigned LevelTableDepth = 16;

  // Charge level thresholds in mV; unused tail entries sit at full scale
  localparam logic [MvW-1:0] LEVEL_MV [LevelTableDepth] = '{
    14'd6000, 14'd6200, 14'd6400, 14'd7360, 14'd7460, 14'd7530, 14'd7600, 14'd7700,
    14'd7860, 14'd8040, 14'd16383, 14'd16383, 14'd16383, 14'd16383, 14'd16383, 14'd16383
  };

  // Reset values
  localparam logic [MvW-1:0]   RST_LOW_MV    = 14'd6400;
  localparam logic [MvW-1:0]   RST_CRIT_MV   = 14'd6000;
  localparam logic [TickW-1:0] RST_LOW_TMO   = 32'd5000;
  localparam logic [TickW-1:0] RST_CRIT_TMO  = 32'd5000;
  localparam logic [TickW-1:0] RST_INACT_TMO = 32'd300000;
  localparam logic [CutW-1:0]  RST_CUTOFF    = 15'd50;
  localparam logic [MvW-1:0]   RST_MIN_SEEN  = 14'd6000;

  localparam logic [7:0] PCT_SAT = 8'd127;

endpackage
`default_nettype wire

// ===== rtl/core/battery_power_state_monitor_top.sv =====
// Top level of the battery power state monitor.
`default_nettype none
// Battery power state monitor. Each input transaction (tuser = request kind) is
// either a voltage sample, a landing check or a force-critical request, and
// produces exactly one result transaction. A sample updates the min/max
// voltage, gives a charge level from a fixed threshold table, restarts the
// low/critical timers while the voltage is above their thresholds, classifies
// the power state and may set the sticky critical flag (critical-low timeout
// in low power, or pilot inactivity on battery). A landing check, once the
// critical flag is set, commands descent above the height cutoff, otherwise
// latches landed and requests disarm. Request kind 3 only reports state.
// Rate: one transaction per clock sustained while m_axis_tready is high; each
// item passes the input register, then the result register. The rate is set
// by the state update, combinational between the input and result registers,
// so the next item always sees the state left by this one.
// Configuration writes (cfg_index_i 0..5; other indexes ignored) are always
// accepted and must only be issued while the block is idle.
// There is no clearing pass after reset.
module battery_power_state_monitor_top #(
  parameter int unsigned LEVEL_ENTRIES = 10  // charge table entries used, 2..16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, low bit up: battery_mv[13:0], now_ticks[45:14], charger_good[46],
  //   is_charging[47], inactivity_ticks[79:48], height_mm[95:80]
  input  wire logic [95:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, low bit up: power_state[1:0], state_changed[2], may_fly[3],
  //   charge_percent[10:4], min_mv[24:11], max_mv[38:25], critical[39],
  //   descend_cmd[40], landed[41], disarm[42], zero pad [47:43]
  output logic [47:0]      m_axis_tdata
);

  localparam int unsigned CntW = $clog2(LEVEL_ENTRIES + 1);
  localparam int unsigned MulW = CntW + 4;
  localparam logic [CntW-1:0] LevelMax = CntW'(LEVEL_ENTRIES - 1);

  // ---------------- configuration registers ----------------
  logic [bpsm_pkg::MvW-1:0]   low_mv_q, crit_mv_q;
  logic [bpsm_pkg::TickW-1:0] low_tmo_q, crit_tmo_q, inact_tmo_q;
  logic [bpsm_pkg::CutW-1:0]  cutoff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_mv_q    <= bpsm_pkg::RST_LOW_MV;
      crit_mv_q   <= bpsm_pkg::RST_CRIT_MV;
      low_tmo_q   <= bpsm_pkg::RST_LOW_TMO;
      crit_tmo_q  <= bpsm_pkg::RST_CRIT_TMO;
      inact_tmo_q <= bpsm_pkg::RST_INACT_TMO;
      cutoff_q    <= bpsm_pkg::RST_CUTOFF;
    end else if (cfg_valid_i) begin
      unique case (bpsm_pkg::cfg_idx_e'(cfg_index_i))
        bpsm_pkg::CFG_LOW_MV:      low_mv_q    <= cfg_data_i[bpsm_pkg::MvW-1:0];
        bpsm_pkg::CFG_CRIT_MV:     crit_mv_q   <= cfg_data_i[bpsm_pkg::MvW-1:0];
        bpsm_pkg::CFG_LOW_TMO:     low_tmo_q   <= cfg_data_i;
        bpsm_pkg::CFG_CRIT_TMO:    crit_tmo_q  <= cfg_data_i;
        bpsm_pkg::CFG_INACT_TMO:   inact_tmo_q <= cfg_data_i;
        bpsm_pkg::CFG_LAND_CUTOFF: cutoff_q    <= cfg_data_i[bpsm_pkg::CutW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic        in_valid_q;
  logic [95:0] in_data_q;
  logic [1:0]  in_req_q;
  logic        advance;

  // the item moves to the result register when that one is free or draining
  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_req_q  <= s_axis_tuser;
    end
  end

  // field unpack
  logic [bpsm_pkg::MvW-1:0]         mv;
  logic [bpsm_pkg::TickW-1:0]       now, inact;
  logic                             pgood, chg;
  logic signed [bpsm_pkg::HgtW-1:0] height;

  assign mv     = in_data_q[13:0];
  assign now    = in_data_q[45:14];
  assign pgood  = in_data_q[46];
  assign chg    = in_data_q[47];
  assign inact  = in_data_q[79:48];
  assign height = $signed(in_data_q[95:80]);

  // ---------------- state ----------------
  logic [bpsm_pkg::TickW-1:0] low_stamp_q, low_stamp_d, crit_stamp_q, crit_stamp_d;
  logic [bpsm_pkg::MvW-1:0]   min_q, min_d, max_q, max_d;
  bpsm_pkg::power_state_e     last_state_q, last_state_d;
  logic                       crit_flag_q, crit_flag_d, landed_q, landed_d;

  // per-item result
  bpsm_pkg::power_state_e     state_r;
  logic                       changed_r, descend_r, disarm_r;
  logic [bpsm_pkg::PctW-1:0]  pct_r;

  // charge level: count of used table entries strictly below the sample
  logic [CntW-1:0] level_cnt, level;
  logic [MulW-1:0] level_x10;
  logic [7:0]      pct_sat;

  always_comb begin
    level_cnt = '0;
    for (int i = 0; i < LEVEL_ENTRIES; i++) begin
      if (bpsm_pkg::LEVEL_MV[i] < mv) level_cnt = level_cnt + CntW'(1);
    end
    level     = (level_cnt > LevelMax) ? LevelMax : level_cnt;
    level_x10 = MulW'(level) * MulW'(10);
    pct_sat   = (MulW'(level_x10) > MulW'(bpsm_pkg::PCT_SAT)) ? bpsm_pkg::PCT_SAT
              : 8'(level_x10);
  end

  // timer checks; a timer restarted by this sample has age zero and cannot fire
  logic above_low, above_crit, low_expired, crit_expired, inact_expired, above_cut;
  logic [bpsm_pkg::TickW-1:0] low_age, crit_age;

  assign above_low     = mv > low_mv_q;
  assign above_crit    = mv > crit_mv_q;
  assign low_age       = now - low_stamp_q;
  assign crit_age      = now - crit_stamp_q;
  assign low_expired   = !above_low && (low_age > low_tmo_q);
  assign crit_expired  = !above_crit && (crit_age > crit_tmo_q);
  assign inact_expired = inact > inact_tmo_q;
  assign above_cut     = height > $signed({1'b0, cutoff_q});

  always_comb begin
    low_stamp_d  = low_stamp_q;
    crit_stamp_d = crit_stamp_q;
    min_d        = min_q;
    max_d        = max_q;
    last_state_d = last_state_q;
    crit_flag_d  = crit_flag_q;
    landed_d     = landed_q;
    state_r      = last_state_q;
    changed_r    = 1'b0;
    descend_r    = 1'b0;
    disarm_r     = 1'b0;
    pct_r        = '0;

    unique case (bpsm_pkg::req_e'(in_req_q))
      bpsm_pkg::REQ_SAMPLE: begin
        if (mv > max_q) max_d = mv;
        if (mv < min_q) min_d = mv;
        pct_r = pct_sat[bpsm_pkg::PctW-1:0];
        if (above_low)  low_stamp_d  = now;
        if (above_crit) crit_stamp_d = now;
        priority if (pgood && !chg) begin
          state_r = bpsm_pkg::PS_CHARGED;
        end else if (pgood && chg) begin
          state_r = bpsm_pkg::PS_CHARGING;
        end else if (!chg && low_expired) begin
          state_r = bpsm_pkg::PS_LOWPOWER;
        end else begin
          state_r = bpsm_pkg::PS_BATTERY;
        end
        changed_r    = (state_r != last_state_q);
        last_state_d = state_r;
        if ((state_r == bpsm_pkg::PS_LOWPOWER) && crit_expired) crit_flag_d = 1'b1;
        if ((state_r == bpsm_pkg::PS_BATTERY) && inact_expired) crit_flag_d = 1'b1;
      end
      bpsm_pkg::REQ_LANDING: begin
        if (crit_flag_q) begin
          if (above_cut) begin
            descend_r = 1'b1;
          end else begin
            landed_d = 1'b1;
            disarm_r = 1'b1;
          end
        end
      end
      bpsm_pkg::REQ_FORCE: crit_flag_d = 1'b1;
      bpsm_pkg::REQ_NOP:   ;  // report only
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_stamp_q  <= '0;
      crit_stamp_q <= '0;
      min_q        <= bpsm_pkg::RST_MIN_SEEN;
      max_q        <= '0;
      last_state_q <= bpsm_pkg::PS_BATTERY;
      crit_flag_q  <= 1'b0;
      landed_q     <= 1'b0;
    end else if (advance) begin
      low_stamp_q  <= low_stamp_d;
      crit_stamp_q <= crit_stamp_d;
      min_q        <= min_d;
      max_q        <= max_d;
      last_state_q <= last_state_d;
      crit_flag_q  <= crit_flag_d;
      landed_q     <= landed_d;
    end
  end

  // ---------------- result register ----------------
  logic out_valid_q;
  logic [47:0] out_data_q;
  logic may_fly;

  assign may_fly = (state_r == bpsm_pkg::PS_LOWPOWER) || (state_r == bpsm_pkg::PS_BATTERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {5'd0, disarm_r, landed_d, descend_r, crit_flag_d, max_d, min_d,
                     pct_r, may_fly, changed_r, state_r};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== tb/tb_battery_power_state_monitor_top.sv =====
// Self-checking testbench for the battery power state monitor top level.
`timescale 1ns / 100ps

// The block is driven through its request stream with directed and random
// transactions. Each accepted request goes through a local model of the
// monitor, which queues the status word that the block should return. Every
// returned status word is compared field by field with the oldest queued
// one. Threshold registers are reprogrammed only while nothing is in flight.
module tb_battery_power_state_monitor_top;

  localparam int unsigned LEVEL_ENTRIES = 10;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SWEEP_ITEMS   = 175;

  // Charge level steps in mV, lowest first
  localparam logic [13:0] CHARGE_STEP_MV [LEVEL_ENTRIES] = '{
    14'd6000, 14'd6200, 14'd6400, 14'd7360, 14'd7460,
    14'd7530, 14'd7600, 14'd7700, 14'd7860, 14'd8040
  };

  // Request payload, first field in the low bits (matches s_axis_tdata)
  typedef struct packed {
    logic [15:0] height_mm;
    logic [31:0] inactivity_ticks;
    logic        is_charging;
    logic        charger_good;
    logic [31:0] now_ticks;
    logic [13:0] battery_mv;
  } monitor_req_t;

  // Status word, first field in the low bits (matches m_axis_tdata)
  typedef struct packed {
    logic [4:0]  pad;
    logic        disarm;
    logic        landed;
    logic        descend_cmd;
    logic        critical;
    logic [13:0] max_mv;
    logic [13:0] min_mv;
    logic [6:0]  charge_percent;
    logic        may_fly;
    logic        state_changed;
    logic [1:0]  power_state;
  } status_word_t;

  // DUT inputs, all known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [2:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [95:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  // DUT outputs
  logic        cfg_ready_o;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;

  // Model copy of the threshold registers
  logic [13:0] set_low_mv    = 14'd6400;
  logic [13:0] set_crit_mv   = 14'd6000;
  logic [31:0] set_low_tmo   = 32'd5000;
  logic [31:0] set_crit_tmo  = 32'd5000;
  logic [31:0] set_inact_tmo = 32'd300000;
  logic [14:0] set_cutoff    = 15'd50;

  // Model copy of the monitor state
  logic [31:0]            low_since     = '0;
  logic [31:0]            crit_since    = '0;
  logic [13:0]            lowest_mv     = 14'd6000;
  logic [13:0]            highest_mv    = '0;
  bpsm_pkg::power_state_e prev_state    = bpsm_pkg::PS_BATTERY;
  logic                   alarm_latched = 1'b0;
  logic                   touchdown     = 1'b0;

  status_word_t predicted_status[$];
  status_word_t seen_status;
  status_word_t want_status;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  logic        steady         = 1'b0;  // no idling on either side while set
  logic [31:0] tick_now       = '0;    // running tick count for random traffic
  logic [13:0] cell_mv        = 14'd7800;  // slowly sagging battery voltage

  battery_power_state_monitor_top #(
    .LEVEL_ENTRIES(LEVEL_ENTRIES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Model of the monitor
  // ---------------------------------------------------------------------

  function automatic void load_setting(input bpsm_pkg::cfg_idx_e idx,
                                       input logic [31:0] d);
    case (idx)
      bpsm_pkg::CFG_LOW_MV:      set_low_mv    = d[13:0];
      bpsm_pkg::CFG_CRIT_MV:     set_crit_mv   = d[13:0];
      bpsm_pkg::CFG_LOW_TMO:     set_low_tmo   = d;
      bpsm_pkg::CFG_CRIT_TMO:    set_crit_tmo  = d;
      bpsm_pkg::CFG_INACT_TMO:   set_inact_tmo = d;
      bpsm_pkg::CFG_LAND_CUTOFF: set_cutoff    = d[14:0];
      default: ;  // reserved indexes are dropped
    endcase
  endfunction

  function automatic status_word_t predict_status(input bpsm_pkg::req_e kind,
                                                  input monitor_req_t f);
    status_word_t           s;
    bpsm_pkg::power_state_e st;
    int unsigned            steps;
    int                     h;
    int                     i;
    s = '0;
    st = prev_state;
    h = int'($signed(f.height_mm));
    case (kind)
      bpsm_pkg::REQ_SAMPLE: begin
        if (f.battery_mv > highest_mv) highest_mv = f.battery_mv;
        if (f.battery_mv < lowest_mv) lowest_mv = f.battery_mv;
        steps = 0;
        for (i = 0; i < LEVEL_ENTRIES; i++) begin
          if (CHARGE_STEP_MV[i] < f.battery_mv) steps++;
        end
        if (steps > LEVEL_ENTRIES - 1) steps = LEVEL_ENTRIES - 1;
        s.charge_percent = (steps * 10 > 127) ? 7'd127 : 7'(steps * 10);
        // timers restart while the voltage is above their thresholds
        if (f.battery_mv > set_low_mv) low_since = f.now_ticks;
        if (f.battery_mv > set_crit_mv) crit_since = f.now_ticks;
        if (f.charger_good) begin
          st = f.is_charging ? bpsm_pkg::PS_CHARGING : bpsm_pkg::PS_CHARGED;
        end else if (!f.is_charging && 32'(f.now_ticks - low_since) > set_low_tmo) begin
          st = bpsm_pkg::PS_LOWPOWER;
        end else begin
          st = bpsm_pkg::PS_BATTERY;
        end
        s.state_changed = (st != prev_state);
        prev_state = st;
        if (st == bpsm_pkg::PS_LOWPOWER && 32'(f.now_ticks - crit_since) > set_crit_tmo)
          alarm_latched = 1'b1;
        if (st == bpsm_pkg::PS_BATTERY && f.inactivity_ticks > set_inact_tmo)
          alarm_latched = 1'b1;
      end
      bpsm_pkg::REQ_LANDING: begin
        // without the alarm a landing check does nothing
        if (alarm_latched) begin
          if (h > int'(set_cutoff)) begin
            s.descend_cmd = 1'b1;
          end else begin
            touchdown = 1'b1;
            s.disarm  = 1'b1;
          end
        end
      end
      bpsm_pkg::REQ_FORCE: alarm_latched = 1'b1;
      default: ;  // kind 3 only reports the state
    endcase
    s.power_state = st;
    s.may_fly     = (st == bpsm_pkg::PS_LOWPOWER || st == bpsm_pkg::PS_BATTERY);
    s.min_mv      = lowest_mv;
    s.max_mv      = highest_mv;
    s.critical    = alarm_latched;
    s.landed      = touchdown;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Checking, receiver stalls and the stall counter
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, seen, want);
  endtask

  // All handshakes are sampled with pre-edge values; the status word is
  // compared before the request accepted at the same edge is modeled.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_status = m_axis_tdata;
      if (predicted_status.size() == 0) begin
        report_mismatch("unrequested status word", seen_status[31:0], '0);
      end else begin
        want_status = predicted_status.pop_front();
        if (seen_status.power_state !== want_status.power_state)
          report_mismatch("power_state", 32'(seen_status.power_state),
                          32'(want_status.power_state));
        if (seen_status.state_changed !== want_status.state_changed)
          report_mismatch("state_changed", 32'(seen_status.state_changed),
                          32'(want_status.state_changed));
        if (seen_status.may_fly !== want_status.may_fly)
          report_mismatch("may_fly", 32'(seen_status.may_fly), 32'(want_status.may_fly));
        if (seen_status.charge_percent !== want_status.charge_percent)
          report_mismatch("charge_percent", 32'(seen_status.charge_percent),
                          32'(want_status.charge_percent));
        if (seen_status.min_mv !== want_status.min_mv)
          report_mismatch("min_mv", 32'(seen_status.min_mv), 32'(want_status.min_mv));
        if (seen_status.max_mv !== want_status.max_mv)
          report_mismatch("max_mv", 32'(seen_status.max_mv), 32'(want_status.max_mv));
        if (seen_status.critical !== want_status.critical)
          report_mismatch("critical", 32'(seen_status.critical), 32'(want_status.critical));
        if (seen_status.descend_cmd !== want_status.descend_cmd)
          report_mismatch("descend_cmd", 32'(seen_status.descend_cmd),
                          32'(want_status.descend_cmd));
        if (seen_status.landed !== want_status.landed)
          report_mismatch("landed", 32'(seen_status.landed), 32'(want_status.landed));
        if (seen_status.disarm !== want_status.disarm)
          report_mismatch("disarm", 32'(seen_status.disarm), 32'(want_status.disarm));
        if (seen_status.pad !== want_status.pad)
          report_mismatch("pad bits", 32'(seen_status.pad), 32'(want_status.pad));
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predicted_status.push_back(predict_status(bpsm_pkg::req_e'(s_axis_tuser),
                                                monitor_req_t'(s_axis_tdata)));
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      load_setting(bpsm_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Result side backpressure: about one stalled cycle in seven
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 14);
  end

  // Watchdog on cycles with no transaction at all
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("[battery_power_state_monitor_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Drivers; every task starts and ends right after a rising edge
  // ---------------------------------------------------------------------

  function automatic monitor_req_t pack_request(input logic [13:0] mv, input logic [31:0] now,
                                                input logic pg, input logic chg,
                                                input logic [31:0] inact,
                                                input logic [15:0] h);
    monitor_req_t f;
    f.battery_mv       = mv;
    f.now_ticks        = now;
    f.charger_good     = pg;
    f.is_charging      = chg;
    f.inactivity_ticks = inact;
    f.height_mm        = h;
    return f;
  endfunction

  // Leaves tvalid high so back-to-back transactions need no second drive
  task automatic send_request(input bpsm_pkg::req_e kind, input monitor_req_t f);
    logic taken;
    if (!steady && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 14);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    s_axis_tuser  <= kind;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic write_register(input bpsm_pkg::cfg_idx_e idx, input logic [31:0] d);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Holds off the sender until every status word is back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (predicted_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Upper data bits beyond each register width carry junk
  task automatic program_thresholds(input logic [13:0] lo_mv, input logic [13:0] cr_mv,
                                    input logic [31:0] lo_tmo, input logic [31:0] cr_tmo,
                                    input logic [31:0] in_tmo, input logic [14:0] cutoff);
    wait_for_drain();
    write_register(bpsm_pkg::CFG_LOW_MV, {18'($urandom), lo_mv});
    write_register(bpsm_pkg::CFG_CRIT_MV, {18'($urandom), cr_mv});
    write_register(bpsm_pkg::CFG_RSVD6, $urandom);
    write_register(bpsm_pkg::CFG_LOW_TMO, lo_tmo);
    write_register(bpsm_pkg::CFG_CRIT_TMO, cr_tmo);
    write_register(bpsm_pkg::CFG_INACT_TMO, in_tmo);
    write_register(bpsm_pkg::CFG_LAND_CUTOFF, {17'($urandom), cutoff});
    write_register(bpsm_pkg::CFG_RSVD7, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed flight: time moves forward, the battery sags and is
  // recharged now and then, heights hover around the cutoff.
  task automatic run_random_requests(input int unsigned count);
    bpsm_pkg::req_e kind;
    monitor_req_t   f;
    int unsigned    pick;
    repeat (count) begin
      pick = $urandom_range(99);
      kind = (pick < 55) ? bpsm_pkg::REQ_SAMPLE : (pick < 85) ? bpsm_pkg::REQ_LANDING :
             (pick < 94) ? bpsm_pkg::REQ_FORCE : bpsm_pkg::REQ_NOP;
      if ($urandom_range(99) < 3)
        cell_mv = 14'($urandom_range(8400, 6000));
      else
        cell_mv = cell_mv - 14'($urandom_range(40));
      case ($urandom_range(5))
        0: f.battery_mv = 14'($urandom);
        1: f.battery_mv = 14'($urandom_range(8400, 5600));
        2: f.battery_mv = set_low_mv + 14'($urandom_range(16)) - 14'd8;
        3: f.battery_mv = set_crit_mv + 14'($urandom_range(16)) - 14'd8;
        default: f.battery_mv = cell_mv;
      endcase
      pick = $urandom_range(99);
      if (pick < 5)
        tick_now = $urandom;
      else if (pick >= 15)
        tick_now = tick_now + 32'($urandom_range(2500));
      f.now_ticks = tick_now;
      if ($urandom_range(99) < 70) begin
        f.charger_good = 1'b0;
        f.is_charging  = 1'b0;
      end else begin
        f.charger_good = 1'($urandom);
        f.is_charging  = 1'($urandom);
      end
      case ($urandom_range(2))
        0: f.inactivity_ticks = $urandom;
        1: f.inactivity_ticks = $urandom_range(1000);
        default: f.inactivity_ticks = set_inact_tmo + 32'($urandom_range(2)) - 32'd1;
      endcase
      if ($urandom_range(1))
        f.height_mm = {1'b0, set_cutoff} + 16'($urandom_range(4)) - 16'd2;
      else
        f.height_mm = 16'($urandom);
      send_request(kind, f);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Before any alarm a landing check changes nothing; kind 3 just reports
  task automatic test_landing_without_alarm();
    send_request(bpsm_pkg::REQ_NOP, pack_request(14'($urandom), $urandom, 1'b1, 1'b1,
                                                 $urandom, 16'h7fff));
    send_request(bpsm_pkg::REQ_LANDING, pack_request(14'd0, 32'd0, 1'b0, 1'b0, 32'd0,
                                                     16'h8000));
    send_request(bpsm_pkg::REQ_LANDING, pack_request(14'h3fff, '1, 1'b1, 1'b1, '1,
                                                     16'h0000));
    send_request(bpsm_pkg::REQ_LANDING, pack_request(14'($urandom), $urandom, 1'b0, 1'b1,
                                                     $urandom, 16'h7fff));
  endtask

  // Voltage extremes, table edges, every charger combination; inactivity
  // stays at or below its limit whenever the state is battery.
  task automatic test_sample_extremes();
    send_request(bpsm_pkg::REQ_SAMPLE, pack_request(14'd0, 32'd0, 1'b1, 1'b0, 32'd0,
                                                    16'($urandom)));
    send_request(bpsm_pkg::REQ_SAMPLE, pack_request(14'h3fff, 32'd100, 1'b1, 1'b1, '1,
                                                    16'h8000));
    send_request(bpsm_pkg::REQ_SAMPLE, pack_request(14'd6000, 32'd200, 1'b0, 1'b1,
                                                    32'd300000, 16'h7fff));
    send_request(bpsm_pkg::REQ_SAMPLE, pack_request(14'd6001, 32'd300, 1'b0, 1'b0, 32'd0,
                                                    16'd0));
    send_request(bpsm_pkg::REQ_SAMPLE, pack_request(14'd8040, 32'd400, 1'b1, 1'b0, 32'd0,
                                                    16'd0));
    send_request(bpsm_pkg::REQ_SAMPLE, pack_request(14'd8041, 32'hffff_f000, 1'b0, 1'b0,
                                                    32'd1, 16'd0));
  endtask

  // Sag below both thresholds while the tick count wraps: low power first,
  // then the critical-low timeout raises the alarm.
  task automatic test_low_power_timeout();
    logic [31:0] now;
    for (int unsigned k = 1; k <= 8; k++) begin
      now = 32'hffff_f000 + k * 1500;
      send_request(bpsm_pkg::REQ_SAMPLE,
                   pack_request((k <= 3) ? 14'd6300 : 14'd5900, now,
                                1'b0, 1'b0, 32'd0, 16'($urandom)));
    end
  endtask

  // With the alarm up: descend above the cutoff, land at or below it, and
  // a landed monitor keeps answering the usual way.
  task automatic test_landing_and_force();
    send_request(bpsm_pkg::REQ_LANDING, pack_request(14'd0, 32'd0, 1'b0, 1'b0, 32'd0,
                                                     16'd51));
    send_request(bpsm_pkg::REQ_LANDING, pack_request(14'd0, 32'd0, 1'b0, 1'b0, 32'd0,
                                                     16'd50));
    send_request(bpsm_pkg::REQ_LANDING, pack_request(14'd0, 32'd0, 1'b0, 1'b0, 32'd0,
                                                     16'h8000));
    send_request(bpsm_pkg::REQ_LANDING, pack_request(14'd0, 32'd0, 1'b0, 1'b0, 32'd0,
                                                     16'h7fff));
    send_request(bpsm_pkg::REQ_FORCE, pack_request(14'($urandom), $urandom, 1'b1, 1'b0,
                                                   $urandom, 16'($urandom)));
    send_request(bpsm_pkg::REQ_NOP, pack_request(14'($urandom), $urandom, 1'b0, 1'b0,
                                                 $urandom, 16'($urandom)));
    send_request(bpsm_pkg::REQ_SAMPLE, pack_request(14'd7000, 32'h0000_4000, 1'b0, 1'b1,
                                                    '1, 16'd0));
  endtask

  // Register settings from all-zero to all-ones, then random ones; the
  // last phase runs with no idling anywhere.
  task automatic test_threshold_sweep();
    logic [13:0] lo;
    program_thresholds('0, '0, '0, '0, '0, '0);
    run_random_requests(SWEEP_ITEMS);
    program_thresholds('1, '1, '1, '1, '1, '1);
    run_random_requests(SWEEP_ITEMS);
    program_thresholds(14'd6400, 14'd6000, 32'd5000, 32'd5000, 32'd300000, 15'd50);
    run_random_requests(SWEEP_ITEMS);
    lo = 14'($urandom_range(8000, 6000));
    program_thresholds(lo, 14'($urandom_range(lo, 5600)), $urandom_range(20000),
                       $urandom_range(20000), $urandom_range(1000000),
                       15'($urandom_range(500)));
    run_random_requests(SWEEP_ITEMS);
    program_thresholds(14'($urandom), 14'($urandom), $urandom, $urandom, $urandom,
                       15'($urandom));
    run_random_requests(SWEEP_ITEMS);
    program_thresholds(14'd6400, 14'd6000, 32'd5000, 32'd5000, 32'd300000, 15'd50);
    steady <= 1'b1;
    run_random_requests(SWEEP_ITEMS);
    steady <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_landing_without_alarm();
    test_sample_extremes();
    test_low_power_timeout();
    test_landing_and_force();
    test_threshold_sweep();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("[battery_power_state_monitor_top] OK");
    end else begin
      $display("[battery_power_state_monitor_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bpsm_pkg.sv
rtl/core/battery_power_state_monitor_top.sv
tb/tb_battery_power_state_monitor_top.sv
